FILE: design/int_to_decimal_ascii_macros.svh
// Assertion macros used by the int_to_decimal_ascii top level.
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITD_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("itd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITD_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("itd assertion failed");

`endif

FILE: design/itd_pkg.sv
// Package for int_to_decimal_ascii: widths, character codes, types, BCD helper.
`default_nettype none

package itd_pkg;

    localparam int NUM_W          = 32;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int NUM_CELLS      = 10;
    localparam int BITS_PER_CYCLE = 4;
    localparam int CONV_CYCLES    = NUM_W / BITS_PER_CYCLE;
    localparam int CNT_W          = $clog2(CONV_CYCLES);
    localparam int REM_W          = $clog2(NUM_CELLS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [BITS_PER_CYCLE-1:0] carry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_DIGITS
    } itd_state_t;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } cell_ctrl_t;

    // Double-dabble correction: a digit of five or more gets three added
    function automatic digit_t dd_adjust(input digit_t d);
        return (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
    endfunction

endpackage

`default_nettype wire

FILE: design/itd_if.sv
// Channel interfaces: integer words in, character words out.
`default_nettype none

interface itd_in_if import itd_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itd_out_if import itd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

FILE: design/itd_cell.sv
// One BCD digit cell: shift-and-add-3 steps, then shift-up for readout.
`default_nettype none

module itd_cell import itd_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  carry_t     carry_in,
    input  digit_t     digit_in,
    output carry_t     carry_out,
    output digit_t     digit
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t conv_val;

    // Several binary bits per cycle, first step takes the top bit of carry_in
    always_comb
    begin
        digit_t work;
        work      = digit_reg;
        carry_out = '0;
        for (int j = 0; j < BITS_PER_CYCLE; j++)
        begin
            work = dd_adjust(work);
            carry_out[BITS_PER_CYCLE-1-j] = work[DIGIT_W-1];
            work = {work[DIGIT_W-2:0], carry_in[BITS_PER_CYCLE-1-j]};
        end
        conv_val = work;
    end

    always_comb
    begin
        if (ctrl.clear)
            digit_next = '0;
        else if (ctrl.conv)
            digit_next = conv_val;
        else if (ctrl.shift)
            digit_next = digit_in;
        else
            digit_next = digit_reg;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

`default_nettype wire

FILE: design/int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII characters.
// Each accepted integer is turned into its decimal text, one character word
// per output handshake, most significant first: a '-' for negative values,
// then the digits with no leading zeros ('0' for zero); is_last marks the
// final character. The magnitude is fed, four bits a cycle, into a row of ten
// BCD digit cells (shift-and-add-3). The cells then shift up one digit per
// cycle while the output register is free, the top cell giving the next
// character or a leading zero to drop. The minus sign goes out as soon as
// the output register is free, before any digit. A new integer can be taken
// in the cycle after the last character has been loaded into the output
// register.
`default_nettype none
`include "int_to_decimal_ascii_macros.svh"

module int_to_decimal_ascii import itd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    itd_in_if.sink           num,
    itd_out_if.source        text
);

    itd_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              started_reg, started_next;
    logic              sign_pend_reg, sign_pend_next;
    logic [NUM_W-1:0]  mag_reg, mag_next;
    logic              ov_reg, ov_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    cell_ctrl_t        ctrl;
    digit_t            digits [NUM_CELLS];
    carry_t            carries [NUM_CELLS];

    logic [NUM_W-1:0]  raw;
    logic [NUM_W-1:0]  mag_in;
    logic              accept;
    logic              out_free;
    logic              last_digit;
    logic              skip_digit;
    logic              load_digit;
    digit_t            top_digit;

    assign raw       = num.value;
    assign mag_in    = raw[NUM_W-1] ? (~raw) + NUM_W'(1) : raw;
    assign num.ready = (state_reg == ST_IDLE);
    assign accept    = num.valid && num.ready;
    assign out_free  = !ov_reg || text.ready;
    assign top_digit = digits[NUM_CELLS-1];
    assign last_digit = (rem_reg == REM_W'(1));

    genvar k;
    generate
        for (k = 0; k < NUM_CELLS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                itd_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl),
                    .carry_in  (mag_reg[NUM_W-1 -: BITS_PER_CYCLE]),
                    .digit_in  ('0),
                    .carry_out (carries[k]),
                    .digit     (digits[k])
                );
            end
            else
            begin : g_rest
                itd_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl),
                    .carry_in  (carries[k-1]),
                    .digit_in  (digits[k-1]),
                    .carry_out (carries[k]),
                    .digit     (digits[k])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        sign_pend_next = sign_pend_reg;
        mag_next       = mag_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        ctrl           = '0;
        skip_digit     = 1'b0;
        load_digit     = 1'b0;

        // sign goes out as soon as the output register is free
        if (sign_pend_reg && out_free)
        begin
            char_next      = CHAR_MINUS;
            last_next      = 1'b0;
            sign_pend_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.clear     = 1'b1;
                    mag_next       = mag_in;
                    sign_pend_next = raw[NUM_W-1];
                    started_next   = 1'b0;
                    cnt_next       = '0;
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.conv = 1'b1;
                mag_next  = mag_reg << BITS_PER_CYCLE;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CONV_CYCLES - 1))
                begin
                    rem_next     = REM_W'(NUM_CELLS);
                    started_next = 1'b0;
                    state_next   = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (!started_reg && top_digit == '0 && !last_digit)
                    skip_digit = 1'b1;
                else if (out_free && !sign_pend_reg)
                    load_digit = 1'b1;

                if (skip_digit || load_digit)
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - REM_W'(1);
                end
                if (load_digit)
                begin
                    char_next    = CHAR_ZERO + CHAR_W'(top_digit);
                    last_next    = last_digit;
                    started_next = 1'b1;
                    if (last_digit)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if ((sign_pend_reg && out_free) || load_digit)
            ov_next = 1'b1;
        else if (text.ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            started_reg   <= 1'b0;
            sign_pend_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            started_reg   <= started_next;
            sign_pend_reg <= sign_pend_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign text.valid     = ov_reg;
    assign text.char_code = char_reg;
    assign text.is_last   = last_reg;

    `ITD_ASSERT_NEXT(a_accept_conv, clk, rst_n, accept, state_reg == ST_CONV)
    `ITD_ASSERT_IMP(a_rem_range, clk, rst_n, state_reg == ST_DIGITS,
        rem_reg != '0 && rem_reg <= REM_W'(NUM_CELLS))
    `ITD_ASSERT_IMP(a_sign_first, clk, rst_n, sign_pend_reg, !started_reg)
    `ITD_ASSERT_NEXT(a_last_idle, clk, rst_n, load_digit && last_digit,
        state_reg == ST_IDLE && text.valid && text.is_last)

endmodule

`default_nettype wire
